// File: hdl/mbg_pkg.sv
`default_nettype none
package mbg_pkg;

  localparam int CFG_W = 6;
  localparam int RND_W = 16;
  localparam int OUT_CW = 7;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    EVT_RESTART = 2'd0,
    EVT_CARVE   = 2'd1,
    EVT_BACK    = 2'd2,
    EVT_FINISH  = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ADDR_CLR, ADDR_UP, ADDR_MID, ADDR_DN, ADDR_WALL, ADDR_ENTRY, ADDR_EXIT
  } addr_sel_t;

  typedef enum logic [1:0] {COL_WALL, COL_ENTRY, COL_EXIT} col_sel_t;

  typedef enum logic [1:0] {CAP_NONE, CAP_UP, CAP_MID, CAP_DN} cap_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      mem_rd;
    logic      mem_wr;
    logic      wr_clear;
    col_sel_t  col_sel;
    logic      clr_inc;
    logic      init_state;
    logic      item_load;
    cap_t      cap;
    logic      cand_next;
    logic      pick;
    logic      push;
    logic      pop_rd;
    logic      pop_load;
    logic      evt_load;
    event_t    evt_code;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cand_ok;
    logic cand_last;
    logic cnt_zero;
    logic finished;
    logic out_free;
  } status_t;

  // Remainder of a 16-bit value by three, folding base-4 digits.
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] r);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RND_W / 2; i++) begin
      s = s + 5'(r[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) t = t - 3'd6;
    else if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // Slot of the chosen candidate: the (r mod count)-th set bit of the mask.
  function automatic logic [1:0] pick_slot(input logic [3:0] mask,
                                           input logic [RND_W-1:0] r);
    logic [2:0] n;
    logic [1:0] p;
    logic [2:0] seen;
    logic [1:0] slot;
    n = 3'($countones(mask));
    case (n)
      3'd2:    p = {1'b0, r[0]};
      3'd3:    p = mod3(r);
      3'd4:    p = r[1:0];
      default: p = 2'd0;
    endcase
    seen = '0;
    slot = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == {1'b0, p}) slot = 2'(i);
        seen = seen + 3'd1;
      end
    end
    return slot;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mbg_ctrl.sv
`default_nettype none
module mbg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_kind,
  output logic                  in_ready,
  input  wire mbg_pkg::status_t sts,
  output mbg_pkg::cmd_t         cmd
);
  import mbg_pkg::*;

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_CAND = 16'h0004,
    S_R1   = 16'h0008,
    S_R2   = 16'h0010,
    S_R3   = 16'h0020,
    S_PICK = 16'h0040,
    S_CRD  = 16'h0080,
    S_CWR  = 16'h0100,
    S_POP  = 16'h0200,
    S_POPW = 16'h0400,
    S_FRD0 = 16'h0800,
    S_FWR0 = 16'h1000,
    S_FRD1 = 16'h2000,
    S_FWR1 = 16'h4000,
    S_EMIT = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   restart_q, restart_q_next;

  // State register; reset starts the grid clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      restart_q <= 1'b0;
    end else begin
      state     <= state_next;
      restart_q <= restart_q_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    restart_q_next = restart_q;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.addr_sel = ADDR_CLR;
        cmd.mem_wr   = 1'b1;
        cmd.wr_clear = 1'b1;
        cmd.clr_inc  = 1'b1;
        if (sts.clr_last) begin
          cmd.init_state = 1'b1;
          if (restart_q) begin
            cmd.evt_load   = 1'b1;
            cmd.evt_code   = EVT_RESTART;
            restart_q_next = 1'b0;
            state_next     = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          if (!in_kind) begin
            restart_q_next = 1'b1;
            state_next     = S_CLR;
          end else if (sts.finished) begin
            state_next = S_FRD0;
          end else begin
            state_next = S_CAND;
          end
        end
      end
      S_CAND: begin
        if (sts.cand_ok) begin
          cmd.addr_sel = ADDR_UP;
          cmd.mem_rd   = 1'b1;
          state_next   = S_R1;
        end else if (sts.cand_last) begin
          state_next = S_PICK;
        end else begin
          cmd.cand_next = 1'b1;
        end
      end
      S_R1: begin
        cmd.addr_sel = ADDR_MID;
        cmd.mem_rd   = 1'b1;
        cmd.cap      = CAP_UP;
        state_next   = S_R2;
      end
      S_R2: begin
        cmd.addr_sel = ADDR_DN;
        cmd.mem_rd   = 1'b1;
        cmd.cap      = CAP_MID;
        state_next   = S_R3;
      end
      S_R3: begin
        cmd.cap = CAP_DN;
        if (sts.cand_last) begin
          state_next = S_PICK;
        end else begin
          cmd.cand_next = 1'b1;
          state_next    = S_CAND;
        end
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = sts.cnt_zero ? S_POP : S_CRD;
      end
      S_CRD: begin
        cmd.addr_sel = ADDR_WALL;
        cmd.mem_rd   = 1'b1;
        state_next   = S_CWR;
      end
      S_CWR: begin
        cmd.addr_sel = ADDR_WALL;
        cmd.mem_wr   = 1'b1;
        cmd.col_sel  = COL_WALL;
        cmd.push     = 1'b1;
        cmd.evt_load = 1'b1;
        cmd.evt_code = EVT_CARVE;
        state_next   = S_EMIT;
      end
      S_POP: begin
        cmd.pop_rd = 1'b1;
        state_next = S_POPW;
      end
      S_POPW: begin
        cmd.pop_load = 1'b1;
        cmd.evt_load = 1'b1;
        cmd.evt_code = EVT_BACK;
        state_next   = S_EMIT;
      end
      S_FRD0: begin
        cmd.addr_sel = ADDR_ENTRY;
        cmd.mem_rd   = 1'b1;
        state_next   = S_FWR0;
      end
      S_FWR0: begin
        cmd.addr_sel = ADDR_ENTRY;
        cmd.mem_wr   = 1'b1;
        cmd.col_sel  = COL_ENTRY;
        state_next   = S_FRD1;
      end
      S_FRD1: begin
        cmd.addr_sel = ADDR_EXIT;
        cmd.mem_rd   = 1'b1;
        state_next   = S_FWR1;
      end
      S_FWR1: begin
        cmd.addr_sel = ADDR_EXIT;
        cmd.mem_wr   = 1'b1;
        cmd.col_sel  = COL_EXIT;
        cmd.evt_load = 1'b1;
        cmd.evt_code = EVT_FINISH;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/mbg_datapath.sv
`default_nettype none
module mbg_datapath #(
  parameter int MAX_WIDTH   = 32,
  parameter int MAX_HEIGHT  = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mbg_pkg::cmd_t                cmd,
  output mbg_pkg::status_t                  sts,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [mbg_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [mbg_pkg::RND_W-1:0]    rnd_in,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [31:0]                       m_axis_tdata,
  output logic [1:0]                        m_axis_tuser
);
  import mbg_pkg::*;

  localparam int COLS = 2 * MAX_WIDTH + 1;
  localparam int ROWS = 2 * MAX_HEIGHT + 1;
  localparam int XW   = $clog2(COLS);
  localparam int YW   = $clog2(ROWS);
  localparam int RW   = YW;
  localparam int CW   = ((XW > YW) ? XW : YW) + 1;
  localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int VW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int KW   = (VW > 2 * CFG_W) ? VW : 2 * CFG_W;

  logic [CFG_W-1:0] gw, gh, ew, eh;
  logic [RW-1:0]    clr_row;
  logic [XW-1:0]    cur_x, wall_x;
  logic [YW-1:0]    cur_y, wall_y;
  logic [SAW-1:0]   top, push_top, pop_addr;
  logic [VW-1:0]    visited;
  logic [RND_W-1:0] rnd;
  logic [1:0]       cand_k;
  logic [3:0]       mask;
  logic             blocked;
  logic [COLS-1:0]  row_q, wdata, pattern;
  logic [XW+YW-1:0] stack_q;
  event_t           evt;

  logic [COLS-1:0]  tiles [ROWS];
  logic [XW+YW-1:0] stk [STACK_DEPTH];

  logic [CW-1:0]    cx, cy, nx, ny, wxn, wyn, lim_x, lim_y;
  logic             ok;
  logic [XW-1:0]    ix, ixm, ixp, col;
  logic [RW-1:0]    addr;
  logic [2*CFG_W-1:0] total;
  logic             fin;
  logic             stk_we;
  logic [SAW-1:0]   stk_wa;
  logic [XW+YW-1:0] stk_wd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gw <= CFG_W'(8);
      gh <= CFG_W'(8);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  gw <= cfg_data;
        REG_HEIGHT: gh <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Effective grid size, limited to 1..MAX.
  always_comb begin
    if (gw == '0) ew = CFG_W'(1);
    else if (32'(gw) > MAX_WIDTH) ew = CFG_W'(MAX_WIDTH);
    else ew = gw;
    if (gh == '0) eh = CFG_W'(1);
    else if (32'(gh) > MAX_HEIGHT) eh = CFG_W'(MAX_HEIGHT);
    else eh = gh;
  end

  assign lim_x = (CW'(ew) << 1) + CW'(1);
  assign lim_y = (CW'(eh) << 1) + CW'(1);
  assign total = (2*CFG_W)'(ew) * (2*CFG_W)'(eh);
  assign fin   = KW'(visited) >= KW'(total);

  // Candidate cell and the wall between it and the current cell.
  assign cx = CW'(cur_x);
  assign cy = CW'(cur_y);
  always_comb begin
    nx  = cx;
    ny  = cy;
    wxn = cx;
    wyn = cy;
    ok  = 1'b0;
    case (cand_k)
      2'd0: begin
        ok  = cx >= CW'(3);
        nx  = cx - CW'(2);
        wxn = cx - CW'(1);
      end
      2'd1: begin
        ok  = cy >= CW'(3);
        ny  = cy - CW'(2);
        wyn = cy - CW'(1);
      end
      2'd2: begin
        ok  = (cy + CW'(2)) < lim_y;
        ny  = cy + CW'(2);
        wyn = cy + CW'(1);
      end
      default: begin
        ok  = (cx + CW'(2)) < lim_x;
        nx  = cx + CW'(2);
        wxn = cx + CW'(1);
      end
    endcase
  end

  assign ix  = XW'(nx);
  assign ixm = XW'(nx - CW'(1));
  assign ixp = XW'(nx + CW'(1));

  // Row address and column of the bit to open.
  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_CLR:   addr = clr_row;
      ADDR_UP:    addr = RW'(ny - CW'(1));
      ADDR_MID:   addr = RW'(ny);
      ADDR_DN:    addr = RW'(ny + CW'(1));
      ADDR_WALL:  addr = RW'(wyn);
      ADDR_ENTRY: addr = '0;
      ADDR_EXIT:  addr = RW'(CW'(eh) << 1);
      default:    addr = '0;
    endcase
    unique case (cmd.col_sel)
      COL_WALL:  col = XW'(wxn);
      COL_ENTRY: col = XW'(1);
      COL_EXIT:  col = XW'(lim_x - CW'(2));
      default:   col = '0;
    endcase
  end

  // Initial row: paths at odd columns of odd rows.
  always_comb begin
    for (int i = 0; i < COLS; i++) begin
      pattern[i] = clr_row[0] & i[0];
    end
  end

  assign wdata = cmd.wr_clear ? pattern : (row_q | (COLS'(1) << col));

  // Tile grid, one row per word, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) tiles[addr] <= wdata;
    if (cmd.mem_rd) row_q <= tiles[addr];
  end

  // Clearing pass row counter.
  always_ff @(posedge clk) begin
    if (rst) clr_row <= '0;
    else if (cmd.clr_inc) clr_row <= (32'(clr_row) == ROWS - 1) ? '0 : clr_row + RW'(1);
  end

  // Candidate scan: gather the four tiles around each candidate.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      rnd    <= rnd_in;
      cand_k <= '0;
      mask   <= '0;
    end else if (cmd.cand_next) begin
      cand_k <= cand_k + 2'd1;
    end else if (cmd.pick) begin
      cand_k <= pick_slot(mask, rnd);
    end
    case (cmd.cap)
      CAP_UP:  blocked <= row_q[ix];
      CAP_MID: blocked <= blocked | row_q[ixm] | row_q[ixp];
      CAP_DN:  mask[cand_k] <= ~(blocked | row_q[ix]);
      default: ;
    endcase
  end

  // Stack addresses: a full stack overwrites its top, an empty one stays at 0.
  assign push_top = (32'(top) + 1 < STACK_DEPTH) ? top + SAW'(1) : top;
  assign pop_addr = (top != '0) ? top - SAW'(1) : '0;
  assign stk_we   = cmd.init_state | cmd.push;
  assign stk_wa   = cmd.init_state ? '0 : push_top;
  assign stk_wd   = cmd.init_state ? {YW'(1), XW'(1)} : {YW'(ny), XW'(nx)};

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    if (cmd.pop_rd) stack_q <= stk[pop_addr];
  end

  // Walk state: current cell, stack top and visited count.
  always_ff @(posedge clk) begin
    if (rst || cmd.init_state) begin
      top     <= '0;
      cur_x   <= XW'(1);
      cur_y   <= YW'(1);
      visited <= VW'(1);
    end else if (cmd.push) begin
      top     <= push_top;
      cur_x   <= XW'(nx);
      cur_y   <= YW'(ny);
      visited <= visited + VW'(1);
    end else begin
      if (cmd.pop_rd) top <= pop_addr;
      if (cmd.pop_load) begin
        cur_x <= stack_q[XW-1:0];
        cur_y <= stack_q[XW+YW-1:XW];
      end
    end
  end

  // Event and opened wall of the pending result.
  always_ff @(posedge clk) begin
    if (cmd.evt_load) begin
      evt    <= cmd.evt_code;
      wall_x <= (cmd.evt_code == EVT_CARVE) ? XW'(wxn) : '0;
      wall_y <= (cmd.evt_code == EVT_CARVE) ? YW'(wyn) : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {3'b000, fin, OUT_CW'(wall_y), OUT_CW'(wall_x),
                       OUT_CW'(cur_y), OUT_CW'(cur_x)};
      m_axis_tuser <= evt;
    end
  end

  assign sts.clr_last  = 32'(clr_row) == ROWS - 1;
  assign sts.cand_ok   = ok;
  assign sts.cand_last = cand_k == 2'd3;
  assign sts.cnt_zero  = mask == '0;
  assign sts.finished  = fin;
  assign sts.out_free  = !m_axis_tvalid || m_axis_tready;

  a_cell_odd: assert property (@(posedge clk) disable iff (rst)
    cur_x[0] && cur_y[0])
    else $error("current cell left the odd-odd lattice");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("grid read and write in the same cycle");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> visited == $past(visited) + VW'(1))
    else $error("carve did not count a visited cell");

endmodule
`default_nettype wire

// File: hdl/maze_backtracker_generator_core.sv
`default_nettype none
// Randomized depth-first maze carver over a (2W+1) by (2H+1) tile grid. Each
// request on the slave stream gives one result on the master stream. In a carving
// step the four neighbor checks read three grid rows each through the single
// port of the row memory, one row per cycle, then the carve reads and rewrites
// the wall row. A finishing step reads and rewrites the entry row, then the exit
// row; a backtracking step runs the neighbor checks, then pops the stack. A
// restart sweeps the grid memory one row per cycle; the same sweep runs after
// reset, during which no request is taken.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle.
module maze_backtracker_generator_core #(
  parameter int MAX_WIDTH   = 32,
  parameter int MAX_HEIGHT  = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [15:0]               s_axis_tdata,  // random_value
  input  wire logic                      s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // cell_x, cell_y, wall_x, wall_y, done_res, zero fill
  output logic [31:0]                    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // event_res
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [mbg_pkg::CFG_W-1:0] cfg_data
);
  import mbg_pkg::*;

  cmd_t    cmd;
  status_t sts;

  mbg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbg_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rnd_in        (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
